@@ rtl/core/pcr_ext_pkg.sv @@
// constants and helper functions for the sha-1 pcr bank extend block
// depends on nothing; used by pcr_bank_sha1_extend through scoped names
package pcr_ext_pkg;

   localparam int NUM_REGS       = 24;
   localparam int DIGEST_BYTES   = 20;
   localparam int WORDS_PER_REG  = 5;
   localparam int WORD_W         = 32;
   localparam int ROW_W          = WORDS_PER_REG * WORD_W;
   localparam int REG_IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int FIRST_ONES_REG = 17;
   localparam int END_ONES_REG   = 23;
   localparam int ROUNDS         = 80;
   localparam int ROUND_W        = 7;
   localparam int SCHED_WORDS    = 16;

   // operation codes carried in req_tuser
   localparam logic OP_EXTEND = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // status codes carried in rsp_tuser
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_BAD_IDX = 1'b1;

   // sha-1 initial chaining value
   localparam logic [WORD_W-1:0] IV_A = 32'h6745_2301;
   localparam logic [WORD_W-1:0] IV_B = 32'hEFCD_AB89;
   localparam logic [WORD_W-1:0] IV_C = 32'h98BA_DCFE;
   localparam logic [WORD_W-1:0] IV_D = 32'h1032_5476;
   localparam logic [WORD_W-1:0] IV_E = 32'hC3D2_E1F0;

   // round constants
   localparam logic [WORD_W-1:0] K_0 = 32'h5A82_7999;
   localparam logic [WORD_W-1:0] K_1 = 32'h6ED9_EBA1;
   localparam logic [WORD_W-1:0] K_2 = 32'h8F1B_BCDC;
   localparam logic [WORD_W-1:0] K_3 = 32'hCA62_C1D6;

   // padding of the single 40-byte message
   localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;
   localparam logic [WORD_W-1:0] MSG_BITS = WORD_W'(2 * DIGEST_BYTES * 8);

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
      logic [2*WORD_W-1:0] dbl;
      dbl = {x, x} << n;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

   // value of a register that was not written since reset
   function automatic logic [ROW_W-1:0] reset_row(input logic [REG_IDX_W-1:0] idx);
      logic ones;
      ones = (32'(idx) >= 32'(FIRST_ONES_REG)) && (32'(idx) < 32'(END_ONES_REG));
      return ones ? {ROW_W{1'b1}} : {ROW_W{1'b0}};
   endfunction

endpackage

@@ rtl/core/pcr_bank_sha1_extend.sv @@
// bank of sha-1 platform configuration registers with extend and read
// depends on pcr_ext_pkg (constants, rotate and reset-value functions)
//
// usage:
//   req channel: req_tuser is the operation (extend or read), req_tdata holds
//   the register index and the 20-byte digest. rsp channel: one transaction per
//   request, rsp_tuser is the status, rsp_tdata the register value afterwards.
//   an index past the bank gives status bad-index, zero data, no change.
// sequencing:
//   one request at a time; req_tready is high only while the sequencer idles.
//   extend: row read, load, 80 rounds of the shared sha-1 round unit at one
//   round a cycle, final add and write-back, result hand-off; read: row read,
//   load, hand-off; bad index: straight to hand-off. req_tready rises in the
//   same cycle as rsp_tvalid.
// reset:
//   synchronous, active high. per-register valid bits clear at once, so every
//   register reads as its reset value (all ones for 17 to 22, else zero) with
//   no clearing pass; the bank memory itself is not touched.
// stalls:
//   the result sits in an output register; a new request is taken while it
//   waits, and a later result holds in the done state until the slot frees.
module pcr_bank_sha1_extend (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] reg_index, [39:8] digest_w0, [71:40] digest_w1, [103:72] digest_w2,
   // [135:104] digest_w3, [167:136] digest_w4
   input  logic [167:0] req_tdata,
   // [0] operation
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] value_w0, [63:32] value_w1, [95:64] value_w2, [127:96] value_w3,
   // [159:128] value_w4
   output logic [159:0] rsp_tdata,
   // [0] status
   output logic         rsp_tuser
);

   localparam int W  = pcr_ext_pkg::WORD_W;
   localparam int RW = pcr_ext_pkg::ROW_W;
   localparam int IW = pcr_ext_pkg::REG_IDX_W;
   localparam int NW = pcr_ext_pkg::WORDS_PER_REG;
   localparam int SW = pcr_ext_pkg::SCHED_WORDS;
   localparam int CW = pcr_ext_pkg::ROUND_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_RD    = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     round_ff, round_in;
   logic [pcr_ext_pkg::NUM_REGS-1:0] row_valid_ff, row_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic              op_ff, op_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [RW-1:0]     digest_ff, digest_in;
   logic [RW-1:0]     rd_row_ff;
   logic              rd_valid_ff;
   logic [W-1:0]      a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [W-1:0]      a_in, b_in, c_in, d_in, e_in;
   logic [W-1:0]      w_ff [SW];
   logic [W-1:0]      w_in [SW];
   logic [RW-1:0]     res_data_ff, res_data_in;
   logic              res_status_ff, res_status_in;
   logic [RW-1:0]     rsp_data_ff, rsp_data_in;
   logic              rsp_status_ff, rsp_status_in;

   // bank memory, one 160-bit row per register, word j at bits [32j +: 32]
   logic [RW-1:0]     bank_mem [pcr_ext_pkg::NUM_REGS];

   logic              req_fire;
   logic              in_range;
   logic              out_free;
   logic [RW-1:0]     old_row;
   logic [RW-1:0]     new_row;
   logic [W-1:0]      f_val, k_val, tmp_val, sched_new;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_range   = req_tdata[7:0] < 8'(pcr_ext_pkg::NUM_REGS);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // a row never written since reset reads as its reset value
   assign old_row = rd_valid_ff ? rd_row_ff : pcr_ext_pkg::reset_row(idx_ff);

   // shared round unit: phase select on the round counter
   always_comb begin
      if (round_ff < CW'(20)) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = pcr_ext_pkg::K_0;
      end else if (round_ff < CW'(40)) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = pcr_ext_pkg::K_1;
      end else if (round_ff < CW'(60)) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = pcr_ext_pkg::K_2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = pcr_ext_pkg::K_3;
      end
   end

   assign tmp_val   = pcr_ext_pkg::rotl(a_ff, 5) + f_val + e_ff + k_val + w_ff[0];
   // window holds w[t..t+15]; next word is w[t+16]
   assign sched_new = pcr_ext_pkg::rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);

   assign new_row = {pcr_ext_pkg::IV_E + e_ff,
                     pcr_ext_pkg::IV_D + d_ff,
                     pcr_ext_pkg::IV_C + c_ff,
                     pcr_ext_pkg::IV_B + b_ff,
                     pcr_ext_pkg::IV_A + a_ff};

   // sequencer
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      row_valid_in  = row_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      digest_in     = digest_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      w_in          = w_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      // output slot drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser;
               idx_in    = req_tdata[IW-1:0];
               digest_in = req_tdata[167:8];
               if (in_range) begin
                  state_in = ST_RD;
               end else begin
                  res_status_in = pcr_ext_pkg::STATUS_BAD_IDX;
                  res_data_in   = '0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_RD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (op_ff == pcr_ext_pkg::OP_READ) begin
               res_status_in = pcr_ext_pkg::STATUS_DONE;
               res_data_in   = old_row;
               state_in      = ST_DONE;
            end else begin
               // message block: old value, digest, pad word, zeros, length
               for (int j = 0; j < NW; j++) begin
                  w_in[j]      = old_row[W*j +: W];
                  w_in[NW + j] = digest_ff[W*j +: W];
               end
               w_in[2*NW] = pcr_ext_pkg::PAD_WORD;
               for (int j = 2*NW + 1; j < SW - 1; j++) begin
                  w_in[j] = '0;
               end
               w_in[SW-1] = pcr_ext_pkg::MSG_BITS;
               a_in     = pcr_ext_pkg::IV_A;
               b_in     = pcr_ext_pkg::IV_B;
               c_in     = pcr_ext_pkg::IV_C;
               d_in     = pcr_ext_pkg::IV_D;
               e_in     = pcr_ext_pkg::IV_E;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            a_in = tmp_val;
            b_in = a_ff;
            c_in = pcr_ext_pkg::rotl(b_ff, 30);
            d_in = c_ff;
            e_in = d_ff;
            for (int j = 0; j < SW - 1; j++) begin
               w_in[j] = w_ff[j+1];
            end
            w_in[SW-1] = sched_new;
            round_in   = round_ff + CW'(1);
            if (round_ff == CW'(pcr_ext_pkg::ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            row_valid_in[idx_ff] = 1'b1;
            res_status_in        = pcr_ext_pkg::STATUS_DONE;
            res_data_in          = new_row;
            state_in             = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      digest_ff     <= digest_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      d_ff          <= d_in;
      e_ff          <= e_in;
      w_ff          <= w_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // bank memory: registered read in the read state, write-back after the add
   always_ff @(posedge clock) begin
      if (state_ff == ST_RD) begin
         rd_row_ff   <= bank_mem[idx_ff];
         rd_valid_ff <= row_valid_ff[idx_ff];
      end
      if (state_ff == ST_ADD) begin
         bank_mem[idx_ff] <= new_row;
      end
   end

   // out-of-range request goes straight to the hand-off state
   a_bad_idx_skips: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !in_range) |=> (state_ff == ST_DONE))
      else $error("bad index did not skip to done");

   // error results carry zero data
   a_bad_idx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == pcr_ext_pkg::STATUS_BAD_IDX)) |-> (rsp_tdata == '0))
      else $error("bad index result with nonzero data");

   // compression leaves the round state only after the last round
   a_round_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROUND) && (round_ff != CW'(pcr_ext_pkg::ROUNDS - 1)))
      |=> (state_ff == ST_ROUND))
      else $error("round sequence cut short");

   // round counter stays inside the 80 rounds
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff < CW'(pcr_ext_pkg::ROUNDS)))
      else $error("round counter out of range");

endmodule
